@@ src/crog_pkg.sv @@
package crog_pkg;

  localparam int WORD_W = 64;
  localparam int SECS_W = 32;
  localparam int TID_W  = 23;
  localparam int MUL_W  = 13;
  localparam int PROD_W = SECS_W + MUL_W;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_NEW   = 2'd0;
  localparam opcode_t OP_READ  = 2'd1;
  localparam opcode_t OP_REG   = 2'd2;
  localparam opcode_t OP_CHECK = 2'd3;

  localparam logic [MUL_W-1:0] CHAL_MUL = 13'h13bd;
  localparam logic [15:0]      CHAL_DIV = 16'hef98;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [WORD_W-1:0] key_word(input logic [2:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      3'd0: w = 64'h12d5d74e22c15f98;
      3'd1: w = 64'h4676a1b4dd9878ef;
      3'd2: w = 64'h45631dbc5ee13756;
      3'd3: w = 64'h14561ce156431abd;
      3'd4: w = 64'hfedc146913213411;
      3'd5: w = 64'h31256746bf4ac953;
      3'd6: w = 64'hbfdd14613136a1ce;
      default: w = 64'h16431645646df1bd;
    endcase
    return w;
  endfunction

endpackage

@@ src/crog_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module crog_div (
  input  logic                       clk,
  input  logic                       rst,
  input  crog_pkg::div_ctl_t         ctl,
  input  logic [crog_pkg::WORD_W-1:0] dividend,
  input  logic [crog_pkg::WORD_W-1:0] divisor,
  output crog_pkg::div_sts_t         sts,
  output logic [crog_pkg::WORD_W-1:0] quotient,
  output logic [crog_pkg::WORD_W-1:0] remainder
);

  localparam int W = crog_pkg::WORD_W;

  logic         busy;
  logic         done;
  logic [5:0]   cnt;
  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic [W-1:0] dvs;

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         ge;

  always_comb begin
    shifted = {rem, quo[W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    ge      = ~diff[W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load on start, then shift and trial-subtract.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ src/challenge_response_owner_gate.sv @@
// Challenge-response ownership gate.
// Input channel: in_valid / in_stall carry one word of opcode, seed_seconds,
// thread_id and response_value. A word is taken when in_valid is high and
// in_stall is low; in_stall stays high while an item is being worked on.
// Output channel: out_valid / out_stall carry status, granted and
// challenge_out, exactly one result word per input word, in order.
// Work per item, from accept to result register: read and check go
// straight to the result, a new challenge takes one division, and a
// register attempt takes eight key-word divisions, then the compare, the
// reseed and the push. All divisions run on the single radix-2 divider,
// which produces one quotient bit per cycle and serves both the challenge
// derivation and the response sum. One item is in work at a time.
// A result that the receiver stalls waits in the output register; the block
// still takes the next word and holds its own result until the register
// frees up.
// Reset (rst, synchronous): challenge cleared, no owner, both channels idle.
module challenge_response_owner_gate (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [31:0]                 seed_seconds,
  input  logic [22:0]                 thread_id,
  input  logic [63:0]                 response_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        status,
  output logic                        granted,
  output logic [63:0]                 challenge_out
);

  localparam int W = crog_pkg::WORD_W;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_CH_MUL     = 4'd1;
  localparam logic [3:0] S_CH_WAIT    = 4'd2;
  localparam logic [3:0] S_RESP_START = 4'd3;
  localparam logic [3:0] S_RESP_WAIT  = 4'd4;
  localparam logic [3:0] S_ACC_Q      = 4'd5;
  localparam logic [3:0] S_ACC_R      = 4'd6;
  localparam logic [3:0] S_CMP        = 4'd7;
  localparam logic [3:0] S_PUSH       = 4'd8;

  logic [3:0]                    state;
  logic [W-1:0]                  challenge;
  logic [crog_pkg::TID_W-1:0]    owner_thread;
  logic                          owner_valid;

  // Item working registers.
  logic [crog_pkg::PROD_W-1:0]   prod;
  logic [crog_pkg::TID_W-1:0]    tid;
  logic [W-1:0]                  resp;
  logic [W-1:0]                  dval;
  logic [W-1:0]                  sum;
  logic [2:0]                    widx;

  // Pending result, moved to the output register when it is free.
  logic                          res_status;
  logic                          res_granted;
  logic [W-1:0]                  res_chal;

  crog_pkg::div_ctl_t            div_ctl;
  crog_pkg::div_sts_t            div_sts;
  logic [W-1:0]                  div_dividend;
  logic [W-1:0]                  div_divisor;
  logic [W-1:0]                  div_quo;
  logic [W-1:0]                  div_rem;

  logic                          in_take;
  logic                          out_free;
  logic                          owner_hit;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign owner_hit = owner_valid && (owner_thread == thread_id);

  // Feed the shared divider: challenge derivation or one key word.
  always_comb begin
    div_ctl.start = (state == S_CH_MUL) || (state == S_RESP_START);
    if (state == S_CH_MUL) begin
      div_dividend = {{(W - crog_pkg::PROD_W){1'b0}}, prod};
      div_divisor  = {48'd0, crog_pkg::CHAL_DIV};
    end else begin
      div_dividend = crog_pkg::key_word(widx) ^ dval;
      div_divisor  = dval;
    end
  end

  crog_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      challenge    <= '0;
      owner_thread <= '0;
      owner_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            case (opcode)
              crog_pkg::OP_NEW:  state <= S_CH_MUL;
              crog_pkg::OP_READ: state <= S_PUSH;
              crog_pkg::OP_REG:  state <= S_RESP_START;
              default:           state <= S_PUSH;
            endcase
          end
        end
        S_CH_MUL:     state <= S_CH_WAIT;
        S_CH_WAIT: begin
          if (div_sts.done) begin
            challenge <= div_quo;
            state     <= S_PUSH;
          end
        end
        S_RESP_START: state <= S_RESP_WAIT;
        S_RESP_WAIT: begin
          if (div_sts.done) state <= S_ACC_Q;
        end
        S_ACC_Q:      state <= S_ACC_R;
        S_ACC_R: begin
          state <= (widx == 3'd7) ? S_CMP : S_RESP_START;
        end
        S_CMP: begin
          // Take ownership on a match, then reseed either way.
          if (sum == resp) begin
            owner_thread <= tid;
            owner_valid  <= 1'b1;
          end
          state <= S_CH_MUL;
        end
        S_PUSH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item datapath.
  always_ff @(posedge clk) begin
    if (in_take) begin
      prod <= {{crog_pkg::MUL_W{1'b0}}, seed_seconds}
            * {{crog_pkg::SECS_W{1'b0}}, crog_pkg::CHAL_MUL};
      tid  <= thread_id;
      resp <= response_value;
      dval <= (challenge == {W{1'b1}}) ? {{(W-1){1'b0}}, 1'b1}
                                       : challenge + {{(W-1){1'b0}}, 1'b1};
      sum  <= '0;
      widx <= '0;
      // Check reports the owner; only read carries the challenge out.
      res_status  <= (opcode == crog_pkg::OP_CHECK) && !owner_hit;
      res_granted <= (opcode == crog_pkg::OP_CHECK) && owner_hit;
      res_chal    <= (opcode == crog_pkg::OP_READ) ? challenge : '0;
    end else begin
      case (state)
        S_ACC_Q: sum <= sum + div_quo;
        S_ACC_R: begin
          sum  <= sum + div_rem;
          widx <= widx + 3'd1;
        end
        S_CMP:   res_status <= (sum != resp);
        default: ;
      endcase
    end
  end

  // Output register: load when free, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && out_free) begin
      status        <= res_status;
      granted       <= res_granted;
      challenge_out <= res_chal;
    end
  end

`ifndef SYNTHESIS
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_CH_WAIT || state == S_RESP_WAIT))
    else $error("divider finished with no one waiting");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_owner_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(owner_valid) |-> $past(state == S_CMP))
    else $error("owner set outside the compare step");

  a_chal_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(challenge) |-> $past(state == S_CH_WAIT && div_sts.done))
    else $error("challenge changed outside a derivation");

  a_push_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("pending result not moved to output");
`endif

endmodule

@@ bench/owner_gate_checker.sv @@
module owner_gate_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] seed_seconds,
  input  logic [22:0] thread_id,
  input  logic [63:0] response_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        status,
  input  logic        granted,
  input  logic [63:0] challenge_out,
  output int          fail_count,
  output int          pending,
  output logic [63:0] winning_key
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SEED_MUL = 64'h13bd;
  localparam logic [63:0] SEED_DIV = 64'hef98;
  localparam logic [511:0] KEY_BANK = {
    64'h16431645646df1bd, 64'hbfdd14613136a1ce,
    64'h31256746bf4ac953, 64'hfedc146913213411,
    64'h14561ce156431abd, 64'h45631dbc5ee13756,
    64'h4676a1b4dd9878ef, 64'h12d5d74e22c15f98
  };

  typedef struct packed {
    logic        status;
    logic        granted;
    logic [63:0] challenge;
  } gate_word_t;

  gate_word_t  due_results[$];
  logic [63:0] gate_challenge = '0;
  logic [22:0] owner_tid = '0;
  logic        owner_set = 1'b0;
  int          misses = 0;

  function automatic logic [63:0] seeded(input logic [31:0] secs);
    return ({32'd0, secs} * SEED_MUL) / SEED_DIV;
  endfunction

  // divisor is challenge + 1, wrapped to one so it never hits zero
  function automatic logic [63:0] response_for(input logic [63:0] chal);
    logic [63:0] d;
    logic [63:0] v;
    logic [63:0] sum;
    d = (chal == '1) ? 64'd1 : chal + 64'd1;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      v = KEY_BANK[i*64 +: 64] ^ d;
      sum = sum + v / d + v % d;
    end
    return sum;
  endfunction

  assign winning_key = response_for(gate_challenge);
  assign fail_count = misses;

  always @(posedge clk) begin
    gate_word_t seen;
    gate_word_t want;
    if (rst) begin
      gate_challenge <= '0;
      owner_tid <= '0;
      owner_set <= 1'b0;
      due_results.delete();
      pending <= 0;
    end else begin
      // compare first: a word leaving now belongs to an earlier input word
      if (out_valid && !out_stall) begin
        seen = {status, granted, challenge_out};
        if (due_results.size() == 0) begin
          misses++;
          $error("result word with nothing pending: status %0d granted %0d challenge_out %h",
                 status, granted, challenge_out);
        end else begin
          want = due_results.pop_front();
          if (seen.status !== want.status) begin
            misses++;
            $error("status: expected %0d, actual %0d", want.status, seen.status);
          end
          if (seen.granted !== want.granted) begin
            misses++;
            $error("granted: expected %0d, actual %0d", want.granted, seen.granted);
          end
          if (seen.challenge !== want.challenge) begin
            misses++;
            $error("challenge_out: expected %h, actual %h", want.challenge, seen.challenge);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = '0;
        case (opcode)
          crog_pkg::OP_NEW: gate_challenge <= seeded(seed_seconds);
          crog_pkg::OP_READ: want.challenge = gate_challenge;
          crog_pkg::OP_REG: begin
            if (response_for(gate_challenge) == response_value) begin
              owner_tid <= thread_id;
              owner_set <= 1'b1;
            end else begin
              want.status = 1'b1;
            end
            gate_challenge <= seeded(seed_seconds);
          end
          default: begin
            if (owner_set && owner_tid == thread_id) begin
              want.granted = 1'b1;
            end else begin
              want.status = 1'b1;
            end
          end
        endcase
        due_results.push_back(want);
      end
      pending <= due_results.size();
    end
  end

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest run: ~520 words, each a register attempt plus sender gaps and
  // receiver stalls; take that several times over.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_WORDS = 500;
  localparam int SETTLE_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  crog_pkg::opcode_t opcode = crog_pkg::OP_NEW;
  logic [31:0]       seed_seconds = '0;
  logic [22:0]       thread_id = '0;
  logic [63:0]       response_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              status;
  logic              granted;
  logic [63:0]       challenge_out;

  int          fail_count;
  int          pending;
  logic [63:0] winning_key;

  int          gap_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  int          words_sent = 0;
  logic [22:0] last_tid = '0;

  always #5 clk = ~clk;

  challenge_response_owner_gate dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .seed_seconds   (seed_seconds),
    .thread_id      (thread_id),
    .response_value (response_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted        (granted),
    .challenge_out  (challenge_out)
  );

  owner_gate_checker gate_watch (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .seed_seconds   (seed_seconds),
    .thread_id      (thread_id),
    .response_value (response_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted        (granted),
    .challenge_out  (challenge_out),
    .fail_count     (fail_count),
    .pending        (pending),
    .winning_key    (winning_key)
  );

  // Receiver side: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Lean on the edges of the seconds range now and then.
  function automatic logic [31:0] pick_secs();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [22:0] pick_tid();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return 23'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until taken. With take_key set, first idle
  // so the predicted challenge settles, then offer the winning
  // response (one bit flipped when spoil is set). Valid stays high on
  // return so back-to-back words need no extra toggle.
  task automatic send_word(input crog_pkg::opcode_t op, input logic [31:0] secs,
                           input logic [22:0] tid, input logic [63:0] resp,
                           input bit take_key, input bit spoil);
    logic [63:0] offer;
    offer = resp;
    if (take_key) begin
      in_valid <= 1'b0;
      @(posedge clk);
      offer = winning_key;
      if (spoil) offer = offer ^ (64'd1 << $urandom_range(63));
    end
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    seed_seconds   <= secs;
    thread_id      <= tid;
    response_value <= offer;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and hold off until every pending result word is out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A proper ownership handoff: fresh challenge, optional read, the right
  // (or, sometimes, a corrupted) response, then checks for the owner and
  // for a neighbor thread.
  task automatic run_handoff();
    logic [22:0] t;
    t = pick_tid();
    send_word(crog_pkg::OP_NEW, pick_secs(), pick_tid(), rand64(), 1'b0, 1'b0);
    if ($urandom_range(1)) begin
      send_word(crog_pkg::OP_READ, pick_secs(), pick_tid(), rand64(), 1'b0, 1'b0);
    end
    send_word(crog_pkg::OP_REG, pick_secs(), t, rand64(), 1'b1, $urandom_range(5) == 0);
    send_word(crog_pkg::OP_CHECK, pick_secs(), t, rand64(), 1'b0, 1'b0);
    send_word(crog_pkg::OP_CHECK, pick_secs(), t ^ (23'd1 << $urandom_range(22)),
              rand64(), 1'b0, 1'b0);
    last_tid = t;
  endtask

  // Noise: any opcode with random content; registers mostly miss.
  task automatic noise_word();
    crog_pkg::opcode_t op;
    op = crog_pkg::opcode_t'($urandom_range(3));
    case (op)
      crog_pkg::OP_REG: begin
        if ($urandom_range(1)) begin
          send_word(op, pick_secs(), pick_tid(), rand64(), 1'b0, 1'b0);
        end else begin
          send_word(op, pick_secs(), pick_tid(), rand64(), 1'b1, 1'b1);
        end
      end
      crog_pkg::OP_CHECK: begin
        send_word(op, pick_secs(), $urandom_range(1) ? last_tid : pick_tid(), rand64(),
                  1'b0, 1'b0);
      end
      default: send_word(op, pick_secs(), pick_tid(), rand64(), 1'b0, 1'b0);
    endcase
  endtask

  initial begin
    int goal;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: no owner yet, zero challenge, extremes of every field.
    send_word(crog_pkg::OP_CHECK, '0, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_READ, '1, '1, '1, 1'b0, 1'b0);
    // register against the reset challenge, reseed from the top of the range
    send_word(crog_pkg::OP_REG, '1, 23'h7fffff, '0, 1'b1, 1'b0);
    send_word(crog_pkg::OP_READ, '0, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_CHECK, '0, 23'h7fffff, '1, 1'b0, 1'b0);
    send_word(crog_pkg::OP_CHECK, '1, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_REG, '0, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_READ, '0, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_REG, 32'd1, '0, '1, 1'b0, 1'b0);
    send_word(crog_pkg::OP_NEW, '0, '1, '1, 1'b0, 1'b0);
    send_word(crog_pkg::OP_READ, '0, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_NEW, '1, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_READ, '1, '1, '1, 1'b0, 1'b0);
    send_word(crog_pkg::OP_REG, 32'h1234_5678, '0, '0, 1'b1, 1'b0);
    send_word(crog_pkg::OP_CHECK, '0, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_CHECK, '0, 23'h7fffff, '0, 1'b0, 1'b0);
    // hold off with nothing in flight, then try a near-miss response
    drain();
    send_word(crog_pkg::OP_NEW, 32'h8000_0000, '0, '0, 1'b0, 1'b0);
    send_word(crog_pkg::OP_REG, '0, 23'h2a_5555, '0, 1'b1, 1'b1);
    send_word(crog_pkg::OP_CHECK, '0, '0, '0, 1'b0, 1'b0);

    // Random: three idling phases, drained at each boundary.
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          gap_pct = 38;
          stall_pct = 52;
        end
        1: begin
          gap_pct = 52;
          stall_pct = 38;
        end
        default: begin
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      goal = words_sent + RANDOM_WORDS / 3;
      while (words_sent < goal) begin
        if ($urandom_range(9) < 6) begin
          run_handoff();
        end else begin
          noise_word();
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ challenge_response_owner_gate.f @@
src/crog_pkg.sv
src/crog_div.sv
src/challenge_response_owner_gate.sv
bench/owner_gate_checker.sv
bench/tb.sv
